// ===== rtl/core/hgfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hgfs_pkg
// Shared widths, hash constants and helpers for the frequency sketch.
// ----------------------------------------------------------------------------
package hgfs_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int ENTRY_W = KEY_W + CNT_W;
  localparam int RND_W   = 31;
  localparam int FREQ_W  = 31;
  localparam int BETA_W  = 18;
  localparam int LIGHT_W = 5;
  localparam int P_W     = 47;   // power of beta, Q16.16, integer part <= 2^31-1
  localparam int NP_W    = 50;   // one product step before the range check
  localparam int DIV_W   = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Murmur3 x86_32 constants for a single four-byte block
  localparam logic [31:0] HASH_SEED = 32'd123;
  localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2    = 32'h1b873593;
  localparam logic [31:0] MUR_C3    = 32'h85ebca6b;
  localparam logic [31:0] MUR_C4    = 32'hc2b2ae35;
  localparam logic [31:0] MUR_ADD   = 32'he6546b64;
  localparam logic [31:0] MUR_LEN   = 32'd4;

  localparam logic [LIGHT_W-1:0] LIGHT_MAX        = 5'd16;
  localparam logic [FREQ_W-1:0]  FREQ_MAX         = 31'h7fffffff;
  localparam logic [P_W-1:0]     ONE_Q16          = 47'd65536;
  localparam logic [BETA_W-1:0]  DECAY_BASE_RESET = 18'd70779;

  // register index decoded from paddr[2]
  localparam logic [0:0] REG_DECAY_BASE = 1'b0;

  localparam logic       REQ_INSERT = 1'b0;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIV_W-1:0]  div_word_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== rtl/core/hgfs_if.sv =====
// ----------------------------------------------------------------------------
// hgfs_req_if / hgfs_rsp_if
// Valid/ready channels for requests and results of the frequency sketch.
// ----------------------------------------------------------------------------
interface hgfs_req_if;
  import hgfs_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [KEY_W-1:0]   key;
  logic [RND_W-1:0]   random_value;
  modport source(output valid, req_type, key, random_value, input ready);
  modport sink(input valid, req_type, key, random_value, output ready);
endinterface

interface hgfs_rsp_if;
  import hgfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  frequency;
  logic               heavy_hit;
  modport source(output valid, frequency, heavy_hit, input ready);
  modport sink(input valid, frequency, heavy_hit, output ready);
endinterface

// ===== rtl/core/hgfs_ram.sv =====
// ----------------------------------------------------------------------------
// hgfs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hgfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and read one row per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/hgfs_divider.sv =====
// ----------------------------------------------------------------------------
// hgfs_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hgfs_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hgfs_pkg::DIV_W-1:0]    dividend,
  input  logic [hgfs_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [hgfs_pkg::DIV_W-1:0]    remainder
);
  import hgfs_pkg::*;

  logic                        busy;
  logic [$clog2(DIV_W)-1:0]    step;
  logic [DIV_W-1:0]            shift;
  logic [DIV_W-1:0]            dvsr;
  logic [DIV_W:0]              trial;

  assign trial = {remainder, shift[DIV_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        shift     <= dividend;
        dvsr      <= divisor;
        remainder <= '0;
      end else if (busy) begin
        shift <= shift << 1;
        if (trial >= {1'b0, dvsr}) begin
          remainder <= DIV_W'(trial - {1'b0, dvsr});
        end else begin
          remainder <= trial[DIV_W-1:0];
        end
        step <= step + 1'b1;
        if (step == $clog2(DIV_W)'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/heavy_guardian_frequency_sketch_unit.sv =====
// ----------------------------------------------------------------------------
// heavy_guardian_frequency_sketch_unit
// Bucketed heavy/light frequency sketch with probabilistic decay.
// ----------------------------------------------------------------------------
// One transaction at a time. A query runs 6 hash, 2 bucket reduction and 2 row read steps,
// then the scan, a decide step and the output step.
// An insert hit adds a write back; an insert miss adds the power steps up to the smallest
// count, a decay remainder division unless the power overflows, and a write back on decay.
// No new request is taken before the result is shown; the block is ready again once it is.
// After reset the bucket memory is cleared row by row; requests wait, config not.
module heavy_guardian_frequency_sketch_unit #(
  parameter int BUCKETS            = 1024,
  parameter int ENTRIES_PER_BUCKET = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  hgfs_req_if.sink                       req,
  hgfs_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hgfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [hgfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [hgfs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import hgfs_pkg::*;

  localparam int BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW        = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int LIGHT_OFF = ENTRIES_PER_BUCKET * ENTRY_W;
  localparam int ROW_W     = LIGHT_OFF + LIGHT_W;
  // reciprocal of the bucket count: ceil(2^(32+HL) / BUCKETS), at most 33 bits
  localparam int HL        = $clog2(BUCKETS);
  localparam logic [63:0] HMUL =
    ((64'd1 << (32 + HL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_HMOD, ST_HRED,
    ST_RD, ST_RDW, ST_SCAN, ST_DECIDE, ST_POW, ST_DMOD, ST_WB, ST_OUT
  } state_t;

  state_t                state;
  logic [BETA_W-1:0]     decay_base;
  logic [BW-1:0]         clr_addr;
  logic [BW-1:0]         bucket;
  logic                  req_q;
  key_t                  key_q;
  logic [RND_W-1:0]      rnd_q;
  logic [31:0]           h;
  logic [31:0]           hq;
  logic [64:0]           hprod;
  logic [BW-1:0]         h_rem;
  logic [ROW_W-1:0]      row;
  logic [EW-1:0]         idx;
  logic [EW-1:0]         slot;
  logic [EW-1:0]         min_idx;
  cnt_t                  min_cnt;
  logic                  hit;
  logic [P_W-1:0]        pw;
  cnt_t                  pow_cnt;
  logic [FREQ_W-1:0]     freq_q;
  logic                  out_valid;
  logic [FREQ_W-1:0]     out_freq;
  logic                  out_hit;
  logic                  div_start;
  div_word_t             div_a;
  div_word_t             div_b;
  logic                  div_done;
  div_word_t             div_rem;
  logic                  ram_we;
  logic [BW-1:0]         ram_addr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;
  key_t                  e_key;
  cnt_t                  e_cnt;
  cnt_t                  hit_cnt;
  logic [LIGHT_W-1:0]    light;
  cnt_t                  qv;
  logic [FREQ_W-1:0]     q_freq;
  logic [NP_W-1:0]       np;
  logic [31:0]           h3_t;
  div_word_t             dvsr;
  logic                  cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_DECAY_BASE);
  assign prdata = (paddr[2:2] == REG_DECAY_BASE) ? PDATA_W'(decay_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_base <= DECAY_BASE_RESET;
    end else if (cfg_wr) begin
      decay_base <= pwdata[BETA_W-1:0];
    end
  end

  // channel wiring
  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.frequency = out_freq;
  assign rsp.heavy_hit = out_hit;

  // bucket row memory: heavy entries plus the light counter
  assign ram_addr  = (state == ST_CLEAR) ? clr_addr : bucket;
  assign ram_we    = (state == ST_CLEAR) || (state == ST_WB);
  assign ram_wdata = (state == ST_CLEAR) ? '0 : row;

  hgfs_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hgfs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  // bucket from the hash: quotient by reciprocal multiply, then the low bits of h - q*B
  always_comb begin
    hprod = 65'(h) * 65'(HMUL[32:0]);
    h_rem = h[BW-1:0] - BW'(hq[BW-1:0] * BW'(BUCKETS));
  end

  // entry under scan, matched entry, query estimate
  always_comb begin
    e_key   = row[idx*ENTRY_W +: KEY_W];
    e_cnt   = row[idx*ENTRY_W + KEY_W +: CNT_W];
    hit_cnt = row[slot*ENTRY_W + KEY_W +: CNT_W];
    light   = row[LIGHT_OFF +: LIGHT_W];
    qv      = hit ? hit_cnt : CNT_W'(light);
    if (qv == '0) begin
      q_freq = FREQ_W'(1);
    end else if (qv > CNT_W'(FREQ_MAX)) begin
      q_freq = FREQ_MAX;
    end else begin
      q_freq = qv[FREQ_W-1:0];
    end
  end

  // one power step: P * beta truncated to Q16.16
  always_comb begin
    np = NP_W'(pw[P_W-1:16]) * NP_W'(decay_base)
       + ((NP_W'(pw[15:0]) * NP_W'(decay_base)) >> 16);
    if (pw[P_W-1:16] == '0) begin
      dvsr = DIV_W'(1);
    end else begin
      dvsr = DIV_W'(pw[P_W-1:16]);
    end
    h3_t = rotl32(HASH_SEED ^ h, 13);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && rsp.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            req_q  <= req.req_type;
            key_q  <= req.key;
            rnd_q  <= req.random_value;
            freq_q <= '0;
            state  <= ST_H1;
          end
        end
        ST_H1: begin
          h     <= key_q * MUR_C1;
          state <= ST_H2;
        end
        ST_H2: begin
          h     <= rotl32(h, 15) * MUR_C2;
          state <= ST_H3;
        end
        ST_H3: begin
          h     <= ((h3_t << 2) + h3_t + MUR_ADD) ^ MUR_LEN;
          state <= ST_H4;
        end
        ST_H4: begin
          h     <= (h ^ (h >> 16)) * MUR_C3;
          state <= ST_H5;
        end
        ST_H5: begin
          h     <= (h ^ (h >> 13)) * MUR_C4;
          state <= ST_H6;
        end
        ST_H6: begin
          h     <= h ^ (h >> 16);
          state <= ST_HMOD;
        end
        ST_HMOD: begin
          hq    <= 32'(hprod >> (32 + HL));
          state <= ST_HRED;
        end
        ST_HRED: begin
          bucket <= h_rem;
          state  <= ST_RD;
        end
        ST_RD: begin
          state <= ST_RDW;
        end
        ST_RDW: begin
          row   <= ram_rdata;
          idx   <= '0;
          hit   <= 1'b0;
          state <= ST_SCAN;
        end
        // walk the entries: first key match, first smallest count
        ST_SCAN: begin
          if (!hit && (e_key == key_q)) begin
            hit  <= 1'b1;
            slot <= idx;
          end
          if ((idx == '0) || (e_cnt < min_cnt)) begin
            min_cnt <= e_cnt;
            min_idx <= idx;
          end
          if (idx == EW'(ENTRIES_PER_BUCKET - 1)) begin
            state <= ST_DECIDE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (req_q != REQ_INSERT) begin
            freq_q <= q_freq;
            state  <= ST_OUT;
          end else if (hit) begin
            if (hit_cnt != '1) begin
              row[slot*ENTRY_W + KEY_W +: CNT_W] <= hit_cnt + 1'b1;
            end
            state <= ST_WB;
          end else begin
            pw      <= ONE_Q16;
            pow_cnt <= '0;
            state   <= ST_POW;
          end
        end
        // raise beta to the smallest count, stop at a fixed point; on overflow skip the decay
        ST_POW: begin
          if ((pow_cnt == min_cnt) || (np == NP_W'(pw))) begin
            div_a     <= DIV_W'(rnd_q);
            div_b     <= dvsr;
            div_start <= 1'b1;
            state     <= ST_DMOD;
          end else if (np[NP_W-1:P_W] != '0) begin
            state <= ST_OUT;
          end else begin
            pw      <= np[P_W-1:0];
            pow_cnt <= pow_cnt + 1'b1;
          end
        end
        // decay the weakest entry, or replace it at a count of at most one, when the random word divides evenly
        ST_DMOD: begin
          if (div_done) begin
            if (div_rem == '0) begin
              if (min_cnt <= CNT_W'(1)) begin
                row[min_idx*ENTRY_W +: KEY_W]          <= key_q;
                row[min_idx*ENTRY_W + KEY_W +: CNT_W] <= '0;
              end else begin
                row[min_idx*ENTRY_W + KEY_W +: CNT_W] <= min_cnt - 1'b1;
                if (light < LIGHT_MAX) begin
                  row[LIGHT_OFF +: LIGHT_W] <= light + 1'b1;
                end
              end
              state <= ST_WB;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_WB: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_freq  <= freq_q;
            out_hit   <= hit;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");

  a_ram_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_CLEAR) || (state == ST_WB)))
    else $error("memory write outside clear or write back");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_H1))
    else $error("accepted request did not start hashing");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside output state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == ST_DMOD))
    else $error("remainder started without a waiting state");
`endif
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and query transactions into the frequency sketch, predicts
// every result with its own bucket model and compares field by field.
// The decay base is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import hgfs_pkg::*;

  localparam int NB       = 1024;
  localparam int NE       = 8;
  localparam int NL       = 16;
  localparam int WD_LIMIT = 40000;
  localparam int DRAIN    = 300;
  localparam int NPOOL_B  = 4;
  localparam int NPOOL_K  = 12;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [RND_W-1:0] rnd;
  } sketch_req_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              hit;
  } sketch_rsp_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  hgfs_req_if req_ch();
  hgfs_rsp_if rsp_ch();

  heavy_guardian_frequency_sketch_unit u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  logic [CNT_W-1:0]   mdl_count [NB*NE];
  logic [KEY_W-1:0]   mdl_key   [NB*NE];
  logic [LIGHT_W-1:0] mdl_light [NB*NL];
  logic [BETA_W-1:0]  mdl_beta;

  sketch_req_t pending_reqs[$];
  sketch_rsp_t expected_rsps[$];
  logic [KEY_W-1:0] bucket_keys[NPOOL_B][NPOOL_K];

  int  in_flight;
  int  fail_cnt;
  int  quiet_cycles;
  bit  calm_send, calm_recv;
  int  send_gap, recv_gap, send_items, recv_items;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur(input logic [31:0] key);
    logic [31:0] k, h;
    k = key * 32'hcc9e2d51;
    k = rol(k, 15);
    k = k * 32'h1b873593;
    h = 32'd123 ^ k;
    h = rol(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // floor(beta^count) in Q16.16 steps; no_decay set once it passes 2^31-1
  function automatic logic [31:0] power_divisor(input logic [31:0] count,
                                                output bit no_decay);
    logic [63:0] p, np, b;
    logic [31:0] i;
    p = 64'd65536;
    b = 64'(mdl_beta);
    no_decay = 1'b0;
    for (i = 0; i < count; i++) begin
      np = (p >> 16) * b + (((p & 64'hffff) * b) >> 16);
      if (np == p) break;
      p = np;
      if ((p >> 16) > 64'h7fffffff) begin
        no_decay = 1'b1;
        return 32'd1;
      end
    end
    if ((p >> 16) == 64'd0) return 32'd1;
    return p[47:16];
  endfunction

  // update the bucket model and return the result for one transaction
  function automatic sketch_rsp_t sketch_predict(input sketch_req_t rq);
    sketch_rsp_t rs;
    int bkt, base, lt, slot, x;
    bit hit, no_decay;
    logic [31:0] v, d;
    bkt  = int'(murmur(rq.key) % NB);
    base = bkt * NE;
    lt   = bkt * NL + bkt % NL;
    hit  = 1'b0;
    slot = 0;
    rs.freq = '0;
    for (int i = 0; i < NE; i++) begin
      if (!hit && mdl_key[base+i] == rq.key) begin
        hit  = 1'b1;
        slot = base + i;
      end
    end
    if (rq.req_type != REQ_INSERT) begin
      v = hit ? mdl_count[slot] : 32'(mdl_light[lt]);
      if (v < 1) v = 1;
      if (v > 32'h7fffffff) v = 32'h7fffffff;
      rs.freq = v[30:0];
    end else if (hit) begin
      if (mdl_count[slot] != 32'hffffffff) mdl_count[slot]++;
    end else begin
      x = base;
      for (int i = 1; i < NE; i++)
        if (mdl_count[base+i] < mdl_count[x]) x = base + i;
      d = power_divisor(mdl_count[x], no_decay);
      if (!no_decay && (32'(rq.rnd) % d) == 0) begin
        if (mdl_count[x] <= 1) begin
          mdl_key[x]   = rq.key;
          mdl_count[x] = '0;
        end else begin
          mdl_count[x]--;
          if (mdl_light[lt] < LIGHT_MAX) mdl_light[lt]++;
        end
      end
    end
    rs.hit = hit;
    return rs;
  endfunction

  // send side: hold each transaction until accepted, then idle a drawn gap
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= 1'b0;
      req_ch.key <= '0;
      req_ch.random_value <= '0;
      send_gap <= 0;
      send_items <= 0;
      calm_send <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        expected_rsps.push_back(sketch_predict({req_ch.req_type, req_ch.key,
                                                req_ch.random_value}));
        in_flight = in_flight + 1;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        sketch_req_t nx;
        nx = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= nx.req_type;
        req_ch.key <= nx.key;
        req_ch.random_value <= nx.rnd;
        send_gap <= calm_send ? 0 : $urandom_range(0, 5);
        send_items <= send_items + 1;
        if (send_items % 97 == 96) calm_send <= ~calm_send;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receive side: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap <= 0;
      recv_items <= 0;
      calm_recv <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result freq=%0d hit=%0d", $time,
                   rsp_ch.frequency, rsp_ch.heavy_hit);
          fail_cnt = fail_cnt + 1;
        end else begin
          sketch_rsp_t ex;
          ex = expected_rsps.pop_front();
          in_flight = in_flight - 1;
          if (ex.freq !== rsp_ch.frequency) begin
            $display("%0t: frequency mismatch expected %0d actual %0d", $time,
                     ex.freq, rsp_ch.frequency);
            fail_cnt = fail_cnt + 1;
          end
          if (ex.hit !== rsp_ch.heavy_hit) begin
            $display("%0t: heavy_hit mismatch expected %0d actual %0d", $time,
                     ex.hit, rsp_ch.heavy_hit);
            fail_cnt = fail_cnt + 1;
          end
        end
        recv_gap <= calm_recv ? 0 : $urandom_range(0, 5);
        recv_items <= recv_items + 1;
        if (recv_items % 89 == 88) calm_recv <= ~calm_recv;
        rsp_ch.ready <= calm_recv;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic write_decay_base(input logic [BETA_W-1:0] beta);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'({REG_DECAY_BASE, 2'b00});
    pwdata <= PDATA_W'(beta);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mdl_beta = beta;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic push_req(input logic rt, input logic [31:0] k, input logic [30:0] r);
    sketch_req_t it;
    it.req_type = rt; it.key = k; it.rnd = r;
    pending_reqs.push_back(it);
  endtask

  function automatic logic [30:0] draw_rnd();
    int c;
    c = $urandom_range(0, 99);
    if (c < 40) return '0;
    if (c < 60) return 31'($urandom_range(0, 7));
    return 31'($urandom);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || req_ch.valid || in_flight != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  initial begin
    logic [BETA_W-1:0] betas[5];
    logic [31:0] k;
    int b, c;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_ch.valid = 1'b0; req_ch.req_type = 1'b0; req_ch.key = '0;
    req_ch.random_value = '0; rsp_ch.ready = 1'b0;
    in_flight = 0; fail_cnt = 0; mdl_beta = DECAY_BASE_RESET;
    for (int i = 0; i < NB*NE; i++) begin mdl_count[i] = '0; mdl_key[i] = '0; end
    for (int i = 0; i < NB*NL; i++) mdl_light[i] = '0;

    // gather keys that collide in a few buckets
    for (int p = 0; p < NPOOL_B; p++) begin
      b = $urandom_range(0, NB - 1);
      c = 0;
      while (c < NPOOL_K) begin
        k = $urandom;
        if (murmur(k) % NB == b) begin bucket_keys[p][c] = k; c++; end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    betas[0] = DECAY_BASE_RESET;
    betas[1] = 18'd65536;
    betas[2] = 18'd262143;
    betas[3] = 18'd131072;
    betas[4] = 18'($urandom_range(65536, 262143));

    // directed: empty entries, key extremes, random word extremes
    push_req(1'b1, 32'h0, 31'h0);
    push_req(1'b0, 32'h0, 31'h7fffffff);
    push_req(1'b1, 32'h0, 31'h0);
    push_req(1'b1, 32'hffffffff, 31'h7fffffff);
    push_req(1'b0, 32'hffffffff, 31'h0);
    push_req(1'b0, 32'hffffffff, 31'h0);
    push_req(1'b1, 32'hffffffff, 31'h0);
    for (int i = 0; i < 10; i++) push_req(1'b0, bucket_keys[0][i], 31'h0);
    push_req(1'b0, bucket_keys[0][10], 31'h0);
    push_req(1'b1, bucket_keys[0][10], 31'h0);
    push_req(1'b1, bucket_keys[0][3], 31'h5555555);
    push_req(1'b0, 32'h80000001, 31'h2aaaaaaa);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_decay_base(betas[ph]);
      // at the largest base, grow one bucket's counts past the decay horizon
      if (ph == 2) begin
        for (int r = 0; r < 20; r++)
          for (int i = 0; i < NE; i++) push_req(1'b0, bucket_keys[1][i], draw_rnd());
        for (int i = 0; i < 8; i++) push_req(1'b0, bucket_keys[1][NE + i % 4], 31'h0);
        for (int i = 0; i < NPOOL_K; i++) push_req(1'b1, bucket_keys[1][i], 31'h0);
      end
      for (int n = 0; n < 260; n++) begin
        c = $urandom_range(0, 99);
        if (c < 70) k = bucket_keys[$urandom_range(0, NPOOL_B-1)][$urandom_range(0, NPOOL_K-1)];
        else if (c < 78) k = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h0;
        else k = $urandom;
        push_req(($urandom_range(0, 99) < 35), k, draw_rnd());
      end
      // hold off until every result of the phase has come back
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
